FILE: rtl/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
package mhpq_pkg;
  localparam int Capacity = 1024;
  localparam int LabelBits = 16;
  localparam int DistBits = 31;
  localparam int AddrBits = $clog2(Capacity + 1);
  localparam int CountBits = $clog2(Capacity + 1);

  localparam logic [1:0] ReqPush = 2'd0;
  localparam logic [1:0] ReqPop = 2'd1;
  localparam logic [1:0] ReqUpdate = 2'd2;
  localparam logic [1:0] ReqNone = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [LabelBits-1:0] vertex_label;
    logic [DistBits-1:0] key_dist;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] popped_label;
    logic [DistBits-1:0] popped_dist;
    logic top_valid;
    logic [15:0] top_label;
    logic [DistBits-1:0] top_dist;
    logic [10:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [LabelBits-1:0] label;
    logic [DistBits-1:0] key;
  } entry_t;
endpackage

FILE: rtl/mhpq_req_if.sv
// Request channel interface.
interface mhpq_req_if;
  import mhpq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/mhpq_rsp_if.sv
// Response channel interface.
interface mhpq_rsp_if;
  import mhpq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/min_heap_priority_queue.sv
// Top level of the min-heap priority queue.
//
//   channel  direction  beat contents
//   req      in         req_type, vertex_label, key_dist
//   rsp      out        status, popped fields, top fields, entry_count
//
// One request is handled at a time; the next request beat is taken once the response beat
// has gone. A push climbs a level per parent read and compare; a pop sinks a level per
// left-child read, right-child read and compare. An update first scans from slot 1
// upwards, a read and a compare a slot, before its sift. Every request ends with a root
// read and the response; a stalled response beat holds the block. Reset is synchronous
// and clears the count and the control state, not the heap memory.
module min_heap_priority_queue (
  input logic clk,
  input logic rst,
  mhpq_req_if.sink req,
  mhpq_rsp_if.source rsp
);
  import mhpq_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_POPRD   = 14'b00000000000010,
    S_POPLAST = 14'b00000000000100,
    S_POPMV   = 14'b00000000001000,
    S_SCANRD  = 14'b00000000010000,
    S_SCAN    = 14'b00000000100000,
    S_DNRDL   = 14'b00000001000000,
    S_DNRDR   = 14'b00000010000000,
    S_DNCMP   = 14'b00000100000000,
    S_UPRD    = 14'b00001000000000,
    S_UPCMP   = 14'b00010000000000,
    S_TOP     = 14'b00100000000000,
    S_CAP     = 14'b01000000000000,
    S_RSP     = 14'b10000000000000
  } state_t;

  state_t state;
  entry_t mem [Capacity+1];
  entry_t rd_q;
  logic rd_en;
  logic [AddrBits-1:0] rd_addr;
  logic wr_en;
  logic [AddrBits-1:0] wr_addr;
  entry_t wr_data;

  logic [CountBits-1:0] count;
  entry_t cur;              // entry being sifted; its slot is a hole until the last write
  logic [AddrBits-1:0] pos; // the hole's slot
  logic [AddrBits-1:0] scan;
  logic upd_pending;        // update: down-or-up decision still open
  entry_t lchild;
  logic [LabelBits-1:0] req_label;
  logic [DistBits-1:0] req_key;

  // Response beat contents, held while the beat waits.
  logic [1:0] status;
  entry_t popped;
  logic top_valid;
  entry_t top;

  // Child slots of the hole and whether they hold entries.
  logic [AddrBits:0] l_idx;
  logic [AddrBits:0] r_idx;
  logic has_left;
  logic has_right;
  assign l_idx = {pos, 1'b0};
  assign r_idx = l_idx + (AddrBits+1)'(1);
  assign has_left = l_idx <= (AddrBits+1)'(count);
  assign has_right = r_idx <= (AddrBits+1)'(count);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Winning child: the left one is held in lchild, the right one is on rd_q, and the right
  // one wins ties.
  entry_t best;
  logic [AddrBits-1:0] best_idx;
  always_comb begin
    best = lchild;
    best_idx = l_idx[AddrBits-1:0];
    if (has_right && rd_q.key <= lchild.key) begin
      best = rd_q;
      best_idx = r_idx[AddrBits-1:0];
    end
  end

  // Memory reads and writes for each state. A write always lands before the root is read
  // back for the response.
  always_comb begin
    rd_en = 1'b0;
    rd_addr = pos;
    wr_en = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    case (state)
      S_POPRD: begin
        rd_en = 1'b1;
        rd_addr = AddrBits'(1);
      end
      S_POPLAST: begin
        rd_en = 1'b1;
        rd_addr = count[AddrBits-1:0];
      end
      S_SCANRD: begin
        rd_en = 1'b1;
        rd_addr = scan;
      end
      S_DNRDL: begin
        if (has_left) begin
          rd_en = 1'b1;
          rd_addr = l_idx[AddrBits-1:0];
        end else if (!upd_pending) begin
          wr_en = 1'b1;
        end
      end
      S_DNRDR: begin
        if (has_right) begin
          rd_en = 1'b1;
          rd_addr = r_idx[AddrBits-1:0];
        end
      end
      S_DNCMP: begin
        if (best.key <= cur.key) begin
          wr_en = 1'b1;
          wr_data = best;
        end else if (!upd_pending) begin
          wr_en = 1'b1;
        end
      end
      S_UPRD: begin
        if (pos == AddrBits'(1)) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
          rd_addr = pos >> 1;
        end
      end
      S_UPCMP: begin
        wr_en = 1'b1;
        if (cur.key <= rd_q.key) wr_data = rd_q;
      end
      S_TOP: begin
        rd_en = 1'b1;
        rd_addr = AddrBits'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      upd_pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_label <= req.data.vertex_label;
            req_key <= req.data.key_dist;
            popped <= '0;
            case (req.data.req_type)
              ReqPush: begin
                if (count >= CountBits'(Capacity)) begin
                  status <= StFull;
                  state <= S_TOP;
                end else begin
                  status <= StOk;
                  count <= count + CountBits'(1);
                  pos <= count + CountBits'(1);
                  cur <= '{label: req.data.vertex_label, key: req.data.key_dist};
                  upd_pending <= 1'b0;
                  state <= S_UPRD;
                end
              end
              ReqPop: begin
                if (count == '0) begin
                  status <= StEmpty;
                  state <= S_TOP;
                end else begin
                  status <= StOk;
                  state <= S_POPRD;
                end
              end
              ReqUpdate: begin
                if (count == '0) begin
                  status <= StNotFound;
                  state <= S_TOP;
                end else begin
                  status <= StOk;
                  scan <= AddrBits'(1);
                  state <= S_SCANRD;
                end
              end
              default: begin
                status <= StOk;
                state <= S_TOP;
              end
            endcase
          end
        end
        S_POPRD: state <= S_POPLAST;
        S_POPLAST: begin
          // rd_q holds the root; the last entry is being read.
          popped <= rd_q;
          count <= count - CountBits'(1);
          if (count == CountBits'(1)) state <= S_TOP;
          else state <= S_POPMV;
        end
        S_POPMV: begin
          cur <= rd_q;
          pos <= AddrBits'(1);
          upd_pending <= 1'b0;
          state <= S_DNRDL;
        end
        S_SCANRD: state <= S_SCAN;
        S_SCAN: begin
          if (rd_q.label == req_label) begin
            cur <= '{label: rd_q.label, key: req_key};
            pos <= scan;
            upd_pending <= 1'b1;
            state <= S_DNRDL;
          end else if (scan >= count) begin
            status <= StNotFound;
            state <= S_TOP;
          end else begin
            scan <= scan + AddrBits'(1);
            state <= S_SCANRD;
          end
        end
        S_DNRDL: begin
          if (has_left) begin
            state <= S_DNRDR;
          end else if (upd_pending) begin
            upd_pending <= 1'b0;
            state <= S_UPRD;
          end else begin
            state <= S_TOP;
          end
        end
        S_DNRDR: begin
          lchild <= rd_q;
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (best.key <= cur.key) begin
            pos <= best_idx;
            upd_pending <= 1'b0;
            state <= S_DNRDL;
          end else if (upd_pending) begin
            // An update whose entry no child beats climbs instead.
            upd_pending <= 1'b0;
            state <= S_UPRD;
          end else begin
            state <= S_TOP;
          end
        end
        S_UPRD: begin
          if (pos == AddrBits'(1)) state <= S_TOP;
          else state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (cur.key <= rd_q.key) begin
            pos <= pos >> 1;
            state <= S_UPRD;
          end else begin
            state <= S_TOP;
          end
        end
        S_TOP: state <= S_CAP;
        S_CAP: begin
          top_valid <= count != '0;
          if (count != '0) top <= rd_q;
          else top <= '0;
          state <= S_RSP;
        end
        S_RSP: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready = state == S_IDLE;
  assign rsp.valid = state == S_RSP;
  assign rsp.data = '{status: status, popped_label: 16'(popped.label), popped_dist: popped.key,
                      top_valid: top_valid, top_label: 16'(top.label), top_dist: top.key,
                      entry_count: 11'(count)};

  // Count never exceeds the capacity.
  a_cap: assert property (@(posedge clk) disable iff (rst) count <= CountBits'(Capacity))
    else $error("count above capacity");
  // A response beat and a request beat never coincide.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(rsp.valid && req.ready))
    else $error("request taken while response pending");
  // A full push leaves the count unchanged.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.data.req_type == ReqPush && count == CountBits'(Capacity))
    |=> count == CountBits'(Capacity)) else $error("push on full changed count");
  // A waiting response beat stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
    else $error("response beat changed while waiting");
endmodule

FILE: sim/min_heap_priority_queue_tb.sv
// Self-checking testbench for the min-heap priority queue: directed and random beats.
module min_heap_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mhpq_req_if req_ch();
  mhpq_rsp_if rsp_ch();

  min_heap_priority_queue u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow heap, one-based like the block, with its own entry count.
  logic [LabelBits-1:0] shadow_label [0:Capacity];
  logic [DistBits-1:0] shadow_dist [0:Capacity];
  int unsigned shadow_count;

  // Responses predicted but not yet seen on the response channel.
  rsp_t pending_rsp [$];

  int unsigned fail_count = 0;
  bit req_idle_en = 1'b1;
  bit rsp_idle_en = 1'b1;
  // When set, the receiver stops taking beats for a stall whose length hold_cycles gives.
  bit hold_req = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  localparam int unsigned CycleLimit = 20_000_000;

  // Labels pushed so far, so updates mostly hit an entry that exists.
  logic [LabelBits-1:0] known_labels [$];

  function automatic void swap_shadow(int unsigned a, int unsigned b);
    logic [LabelBits-1:0] tl;
    logic [DistBits-1:0] td;
    tl = shadow_label[a]; shadow_label[a] = shadow_label[b]; shadow_label[b] = tl;
    td = shadow_dist[a]; shadow_dist[a] = shadow_dist[b]; shadow_dist[b] = td;
  endfunction

  // Winning child of a slot, or zero if it has none; the right child wins ties.
  function automatic int unsigned winning_child(int unsigned i);
    int unsigned l;
    if (i == 0 || i > shadow_count / 2) return 0;
    l = 2 * i;
    if (l + 1 <= shadow_count && shadow_dist[l+1] <= shadow_dist[l]) return l + 1;
    return l;
  endfunction

  function automatic void sink_entry(int unsigned i);
    int unsigned c;
    forever begin
      c = winning_child(i);
      if (c == 0 || shadow_dist[c] > shadow_dist[i]) return;
      swap_shadow(i, c);
      i = c;
    end
  endfunction

  function automatic void raise_entry(int unsigned i);
    while (i > 1) begin
      if (shadow_dist[i] > shadow_dist[i/2]) return;
      swap_shadow(i, i / 2);
      i = i / 2;
    end
  endfunction

  // Applies one request to the shadow heap and returns the response it causes.
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int unsigned c;
    o = '0;
    case (r.req_type)
      ReqPush: begin
        if (shadow_count >= Capacity) begin
          o.status = StFull;
        end else begin
          shadow_count++;
          shadow_label[shadow_count] = r.vertex_label;
          shadow_dist[shadow_count] = r.key_dist;
          raise_entry(shadow_count);
        end
      end
      ReqPop: begin
        if (shadow_count == 0) begin
          o.status = StEmpty;
        end else begin
          o.popped_label = shadow_label[1];
          o.popped_dist = shadow_dist[1];
          swap_shadow(1, shadow_count);
          shadow_count--;
          sink_entry(1);
        end
      end
      ReqUpdate: begin
        o.status = StNotFound;
        for (int unsigned i = 1; i <= shadow_count; i++) begin
          if (shadow_label[i] == r.vertex_label) begin
            o.status = StOk;
            shadow_dist[i] = r.key_dist;
            c = winning_child(i);
            if (c != 0 && shadow_dist[c] <= shadow_dist[i]) sink_entry(i);
            else raise_entry(i);
            break;
          end
        end
      end
      default: ;
    endcase
    if (shadow_count > 0) begin
      o.top_valid = 1'b1;
      o.top_label = shadow_label[1];
      o.top_dist = shadow_dist[1];
    end
    o.entry_count = shadow_count[10:0];
    return o;
  endfunction

  // Drives one request beat at the falling edge and waits for its acceptance. The beat stays
  // on the wires until the next call or the end of the run takes it down.
  task automatic send_request(logic [1:0] kind, logic [LabelBits-1:0] label,
                              logic [DistBits-1:0] key);
    req_t r;
    int unsigned gap;
    r.req_type = kind;
    r.vertex_label = label;
    r.key_dist = key;
    if (req_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp = {pending_rsp, apply_request(r)};
    if (kind == ReqPush) known_labels = {known_labels, label};
    @(negedge clk);
  endtask

  // Response side: the ready pattern is set at falling edges.
  initial begin
    int unsigned gap;
    rsp_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        // Long stall so the block fills its response stage and stops taking requests.
        rsp_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_req = 1'b0;
      end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 17);
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Compares every accepted response with the oldest prediction, field by field.
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (pending_rsp.size() == 0) begin
        $error("response beat with no prediction waiting");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.popped_label !== want.popped_label) begin
          $error("popped_label: expected %0d, got %0d", want.popped_label, got.popped_label);
          fail_count++;
        end
        if (got.popped_dist !== want.popped_dist) begin
          $error("popped_dist: expected %0d, got %0d", want.popped_dist, got.popped_dist);
          fail_count++;
        end
        if (got.top_valid !== want.top_valid) begin
          $error("top_valid: expected %0d, got %0d", want.top_valid, got.top_valid);
          fail_count++;
        end
        if (got.top_label !== want.top_label) begin
          $error("top_label: expected %0d, got %0d", want.top_label, got.top_label);
          fail_count++;
        end
        if (got.top_dist !== want.top_dist) begin
          $error("top_dist: expected %0d, got %0d", want.top_dist, got.top_dist);
          fail_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("min_heap_priority_queue_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [LabelBits-1:0] pick_label();
    if (known_labels.size() > 0 && $urandom_range(0, 9) != 0)
      return known_labels[$urandom_range(0, known_labels.size() - 1)];
    return LabelBits'($urandom);
  endfunction

  // A distance that is often drawn from a narrow range, so ties are common.
  function automatic logic [DistBits-1:0] pick_dist();
    case ($urandom_range(0, 3))
      0: return DistBits'($urandom_range(0, 7));
      1: return {DistBits{1'b1}};
      default: return DistBits'($urandom);
    endcase
  endfunction

  // Edge cases: empty pop, unfound update, extreme values, ties, the unused code.
  task automatic test_directed();
    send_request(ReqPop, '0, '0);
    send_request(ReqUpdate, 16'h1234, 31'd5);
    send_request(ReqNone, '1, '1);
    send_request(ReqPush, '1, '1);
    send_request(ReqPush, '0, '0);
    send_request(ReqPush, 16'h00ff, 31'd7);
    send_request(ReqPush, 16'h00ff, 31'd7);
    send_request(ReqPush, 16'haaaa, 31'h2aaaaaaa);
    send_request(ReqPush, 16'h5555, 31'h55555555);
    send_request(ReqNone, '0, '0);
    send_request(ReqUpdate, 16'h00ff, 31'd0);
    send_request(ReqUpdate, 16'h0000, {DistBits{1'b1}});
    send_request(ReqUpdate, 16'hffff, 31'd3);
    send_request(ReqUpdate, 16'hbeef, 31'd1);
    repeat (7) send_request(ReqPop, '0, '0);
  endtask

  // Fills the heap to capacity, stalling the receiver at the start, then overfills and drains a part.
  task automatic test_full_heap();
    hold_cycles = 400;
    hold_req = 1'b1;
    for (int i = 0; i < Capacity; i++)
      send_request(ReqPush, LabelBits'($urandom_range(0, 300)), pick_dist());
    send_request(ReqPush, 16'h0001, 31'd0);
    send_request(ReqPush, '1, '1);
    repeat (20) send_request(ReqUpdate, pick_label(), pick_dist());
    repeat (40) send_request(ReqPop, '0, '0);
  endtask

  // Mixed random traffic; updates mostly target known labels.
  task automatic test_random_mix(int unsigned n);
    int unsigned sel;
    known_labels.delete();
    for (int unsigned k = 0; k < n; k++) begin
      sel = $urandom_range(0, 19);
      if (sel < 8) send_request(ReqPush, pick_label(), pick_dist());
      else if (sel < 14) send_request(ReqPop, LabelBits'($urandom), DistBits'($urandom));
      else if (sel < 19) send_request(ReqUpdate, pick_label(), pick_dist());
      else send_request(ReqNone, LabelBits'($urandom), DistBits'($urandom));
      if (known_labels.size() > 64) void'(known_labels.pop_front());
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    shadow_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(80);
    test_full_heap();
    test_random_mix(30);
    // The closing stretch runs with no idling on either side.
    req_idle_en = 1'b0;
    rsp_idle_en = 1'b0;
    test_random_mix(40);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("min_heap_priority_queue_tb: PASS");
    end else begin
      $display("min_heap_priority_queue_tb: FAIL");
    end
    $finish;
  end
endmodule
